FILE: rtl/rpn_pkg.sv
`timescale 1ns / 1ps

package rpn_pkg;

  // Stack and datapath sizing
  localparam int STK_DEPTH = 32;
  localparam int DEPTH_W   = $clog2(STK_DEPTH + 1);
  localparam int ADDR_W    = $clog2(STK_DEPTH);
  localparam int VAL_W     = 64;
  localparam int REQ_W     = 3;
  localparam int STS_W     = 3;
  localparam int CNT_W     = $clog2(VAL_W);

  // Token kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH = 3'd0,
    REQ_ADD  = 3'd1,
    REQ_SUB  = 3'd2,
    REQ_MUL  = 3'd3,
    REQ_DIV  = 3'd4,
    REQ_END  = 3'd5
  } req_t;

  // Status codes of a result beat
  typedef enum logic [STS_W-1:0] {
    STS_ACCEPTED = 3'd0,
    STS_READY    = 3'd1,
    STS_INVALID  = 3'd2,
    STS_DIVZERO  = 3'd3,
    STS_OVERFLOW = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_TOP,
    ST_RD_RHS,
    ST_RD_LHS,
    ST_ALU,
    ST_MUL,
    ST_NEG_N,
    ST_NEG_D,
    ST_DIV,
    ST_FIX,
    ST_WB,
    ST_RESP
  } state_t;

endpackage

FILE: rtl/rpn_stack_evaluator_core.sv
`timescale 1ns / 1ps
// Push and rejected tokens go straight to ST_RESP, end reads the top, operators read
// both operands; add/sub use ST_ALU, multiply and divide loop 64 times on the shared
// 64-bit adder. Throughput: one token at a time; the next token is taken once the
// previous one is handed to the output register, which holds it until the result
// beat is taken. Reset (rst_n low, synchronous) empties the stack and drops any
// pending result; stack contents are not cleared, only read below the current depth.
module rpn_stack_evaluator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rpn_pkg::REQ_W-1:0]           in_req_type,
  input  logic signed [rpn_pkg::VAL_W-1:0]    in_operand_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rpn_pkg::STS_W-1:0]           out_status,
  output logic signed [rpn_pkg::VAL_W-1:0]    out_result_value
);
  import rpn_pkg::*;

  // Control state
  state_t             state_r, state_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Working registers
  logic [REQ_W-1:0]   kind_r, kind_nxt;
  logic [VAL_W-1:0]   a_r, a_nxt;
  logic [VAL_W-1:0]   b_r, b_nxt;
  logic [VAL_W-1:0]   q_r, q_nxt;
  logic [VAL_W-1:0]   res_r, res_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               neg_r, neg_nxt;
  status_t            st_r, st_nxt;
  logic [STS_W-1:0]   out_status_r, out_status_nxt;
  logic [VAL_W-1:0]   out_value_r, out_value_nxt;

  // Stack memory
  logic [VAL_W-1:0]   stack_mem [STK_DEPTH];
  logic [VAL_W-1:0]   rd_data_r;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [VAL_W-1:0]   wr_data;

  // Shared adder
  logic [VAL_W-1:0]   add_a;
  logic [VAL_W-1:0]   add_b;
  logic               add_sub;
  logic [VAL_W:0]     add_sum;

  logic               out_free;
  logic [DEPTH_W-1:0] depth_m1;
  logic [DEPTH_W-1:0] depth_m2;

  assign depth_m1 = depth_r - DEPTH_W'(1);
  assign depth_m2 = depth_r - DEPTH_W'(2);
  assign out_free = !out_valid_r || !out_stall;

  assign add_sum = {1'b0, add_a} + {1'b0, add_b ^ {VAL_W{add_sub}}} + (VAL_W + 1)'(add_sub);

  // Stack write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= stack_mem[rd_addr];
  end

  // Address the top on the first read cycle, the value below it afterwards
  always_comb begin
    if (state_r == ST_RD_TOP) begin
      rd_addr = depth_m1[ADDR_W-1:0];
    end else begin
      rd_addr = depth_m2[ADDR_W-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    q_r          <= q_nxt;
    res_r        <= res_nxt;
    cnt_r        <= cnt_nxt;
    neg_r        <= neg_nxt;
    st_r         <= st_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  // Sequencer: next state, shared adder operands, stack writes
  always_comb begin
    state_nxt      = state_r;
    depth_nxt      = depth_r;
    out_valid_nxt  = out_valid_r && out_stall;
    kind_nxt       = kind_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    q_nxt          = q_r;
    res_nxt        = res_r;
    cnt_nxt        = cnt_r;
    neg_nxt        = neg_r;
    st_nxt         = st_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    wr_en          = 1'b0;
    wr_addr        = depth_r[ADDR_W-1:0];
    wr_data        = in_operand_value;
    add_a          = a_r;
    add_b          = b_r;
    add_sub        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_req_type;
          case (in_req_type)
            REQ_PUSH: begin
              state_nxt = ST_RESP;
              if (depth_r == DEPTH_W'(STK_DEPTH)) begin
                st_nxt    = STS_OVERFLOW;
                depth_nxt = '0;
              end else begin
                wr_en     = 1'b1;
                depth_nxt = depth_r + DEPTH_W'(1);
                st_nxt    = STS_ACCEPTED;
              end
            end
            REQ_END: begin
              if (depth_r == DEPTH_W'(1)) begin
                state_nxt = ST_RD_TOP;
              end else begin
                st_nxt    = STS_INVALID;
                depth_nxt = '0;
                state_nxt = ST_RESP;
              end
            end
            REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV: begin
              if (depth_r < DEPTH_W'(2)) begin
                st_nxt    = STS_INVALID;
                depth_nxt = '0;
                state_nxt = ST_RESP;
              end else begin
                state_nxt = ST_RD_TOP;
              end
            end
            default: begin
              st_nxt    = STS_INVALID;
              depth_nxt = '0;
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      ST_RD_TOP: begin
        state_nxt = ST_RD_RHS;
      end

      // Capture the top value; an end token finishes here
      ST_RD_RHS: begin
        b_nxt = rd_data_r;
        if (kind_r == REQ_END) begin
          res_nxt   = rd_data_r;
          st_nxt    = STS_READY;
          depth_nxt = '0;
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_RD_LHS;
        end
      end

      // Capture the left operand and set up the operation
      ST_RD_LHS: begin
        case (kind_r)
          REQ_ADD, REQ_SUB: begin
            a_nxt     = rd_data_r;
            state_nxt = ST_ALU;
          end
          REQ_MUL: begin
            a_nxt     = '0;
            b_nxt     = rd_data_r;
            q_nxt     = b_r;
            cnt_nxt   = '0;
            state_nxt = ST_MUL;
          end
          default: begin
            if (b_r == '0) begin
              st_nxt    = STS_DIVZERO;
              depth_nxt = '0;
              state_nxt = ST_RESP;
            end else begin
              q_nxt     = rd_data_r;
              neg_nxt   = rd_data_r[VAL_W-1] ^ b_r[VAL_W-1];
              state_nxt = ST_NEG_N;
            end
          end
        endcase
      end

      ST_ALU: begin
        add_sub   = (kind_r == REQ_SUB);
        res_nxt   = add_sum[VAL_W-1:0];
        state_nxt = ST_WB;
      end

      // Shift-and-add multiply, one multiplier bit a cycle
      ST_MUL: begin
        if (q_r[0]) begin
          a_nxt = add_sum[VAL_W-1:0];
        end
        b_nxt   = {b_r[VAL_W-2:0], 1'b0};
        q_nxt   = {1'b0, q_r[VAL_W-1:1]};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(VAL_W - 1)) begin
          res_nxt   = q_r[0] ? add_sum[VAL_W-1:0] : a_r;
          state_nxt = ST_WB;
        end
      end

      // Take the dividend magnitude
      ST_NEG_N: begin
        add_a   = '0;
        add_b   = q_r;
        add_sub = 1'b1;
        if (q_r[VAL_W-1]) begin
          q_nxt = add_sum[VAL_W-1:0];
        end
        state_nxt = ST_NEG_D;
      end

      // Take the divisor magnitude
      ST_NEG_D: begin
        add_a   = '0;
        add_b   = b_r;
        add_sub = 1'b1;
        if (b_r[VAL_W-1]) begin
          b_nxt = add_sum[VAL_W-1:0];
        end
        a_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end

      // Restoring divide, one quotient bit a cycle
      ST_DIV: begin
        add_a   = {a_r[VAL_W-2:0], q_r[VAL_W-1]};
        add_b   = b_r;
        add_sub = 1'b1;
        if (add_sum[VAL_W]) begin
          a_nxt = add_sum[VAL_W-1:0];
        end else begin
          a_nxt = add_a;
        end
        q_nxt   = {q_r[VAL_W-2:0], add_sum[VAL_W]};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(VAL_W - 1)) begin
          state_nxt = ST_FIX;
        end
      end

      // Apply the quotient sign
      ST_FIX: begin
        add_a     = '0;
        add_b     = q_r;
        add_sub   = 1'b1;
        res_nxt   = neg_r ? add_sum[VAL_W-1:0] : q_r;
        state_nxt = ST_WB;
      end

      // Replace the two operands with the result
      ST_WB: begin
        wr_en     = 1'b1;
        wr_addr   = depth_m2[ADDR_W-1:0];
        wr_data   = res_r;
        depth_nxt = depth_m1;
        st_nxt    = STS_ACCEPTED;
        state_nxt = ST_RESP;
      end

      // Hand the status to the output register once it frees up
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_value_nxt  = (st_r == STS_READY) ? res_r : '0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;

`ifndef SYNTHESIS
  // A token beat always moves the sequencer out of idle, stalling the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after token beat");

  // Depth never exceeds the stack
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(STK_DEPTH))
    else $error("stack depth out of range");

  // The divide loop never runs on a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (b_r != '0))
    else $error("divide loop with zero divisor");

  // Only a ready status carries a value
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STS_READY) |-> (out_result_value == '0))
    else $error("nonzero value on non-ready status");
`endif

endmodule

FILE: bench/rpn_stack_evaluator_core_tb.sv
`timescale 1ns / 1ps

module rpn_stack_evaluator_core_tb;
  import rpn_pkg::*;

  localparam int unsigned ITEM_TARGET = 1800;
  localparam int unsigned LONG_HOLD   = 300;
  // Longest quiet stretch is the long receiver hold plus a divide and both gaps;
  // allow several times that before calling the run hung.
  localparam int unsigned IDLE_LIMIT  = 3000;
  localparam int unsigned TAIL_CYCLES = 100;

  // Unused token codes, treated by the block as a broken expression
  localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;

  localparam logic [VAL_W-1:0] VMAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VAL_W-1:0] VMIN  = 64'h8000_0000_0000_0000;
  localparam logic [VAL_W-1:0] VNEG1 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [VAL_W-1:0] VZERO = 64'd0;
  localparam logic [VAL_W-1:0] VONE  = 64'd1;

  typedef struct packed {
    status_t          sts;
    logic [VAL_W-1:0] val;
  } token_result_t;

  typedef struct packed {
    logic [REQ_W-1:0] kind;
    logic [VAL_W-1:0] opnd;
    bit               typed;
    status_t          sts;
    logic [VAL_W-1:0] val;
  } dir_row_t;

  // Directed tokens; typed rows carry their own answer, the rest use the predictor
  localparam dir_row_t DIR_TABLE [0:24] = '{
    '{REQ_END,    VZERO, 1'b1, STS_INVALID,  VZERO},  // end on an empty stack
    '{REQ_SUB,    VZERO, 1'b1, STS_INVALID,  VZERO},  // operator with too few values
    '{REQ_PUSH,   VMAX,  1'b1, STS_ACCEPTED, VZERO},
    '{REQ_PUSH,   VONE,  1'b1, STS_ACCEPTED, VZERO},
    '{REQ_ADD,    VZERO, 1'b1, STS_ACCEPTED, VZERO},
    '{REQ_END,    VZERO, 1'b1, STS_READY,    VMIN},   // add wraps past the top
    '{REQ_PUSH,   VMIN,  1'b1, STS_ACCEPTED, VZERO},
    '{REQ_PUSH,   VNEG1, 1'b1, STS_ACCEPTED, VZERO},
    '{REQ_DIV,    VZERO, 1'b1, STS_ACCEPTED, VZERO},
    '{REQ_END,    VZERO, 1'b1, STS_READY,    VMIN},   // most negative over minus one
    '{REQ_PUSH,   64'd5, 1'b1, STS_ACCEPTED, VZERO},
    '{REQ_PUSH,   VZERO, 1'b1, STS_ACCEPTED, VZERO},
    '{REQ_DIV,    VZERO, 1'b1, STS_DIVZERO,  VZERO},  // zero divisor
    '{REQ_END,    VZERO, 1'b1, STS_INVALID,  VZERO},  // stack was cleared
    '{REQ_PUSH,   64'hFFFF_FFFF_FFFF_FFF9, 1'b0, STS_ACCEPTED, VZERO},
    '{REQ_PUSH,   64'd2, 1'b0, STS_ACCEPTED, VZERO},
    '{REQ_DIV,    VZERO, 1'b0, STS_ACCEPTED, VZERO},
    '{REQ_PUSH,   VMIN,  1'b0, STS_ACCEPTED, VZERO},
    '{REQ_MUL,    VZERO, 1'b0, STS_ACCEPTED, VZERO},
    '{REQ_PUSH,   64'hAAAA_AAAA_AAAA_AAAA, 1'b0, STS_ACCEPTED, VZERO},
    '{REQ_SUB,    VZERO, 1'b0, STS_ACCEPTED, VZERO},
    '{REQ_END,    VZERO, 1'b0, STS_ACCEPTED, VZERO},
    '{REQ_SPARE6, VNEG1, 1'b1, STS_INVALID,  VZERO},
    '{REQ_PUSH,   VONE,  1'b1, STS_ACCEPTED, VZERO},
    '{REQ_SPARE7, VZERO, 1'b1, STS_INVALID,  VZERO}
  };

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [REQ_W-1:0]        in_req_type = '0;
  logic signed [VAL_W-1:0] in_operand_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [STS_W-1:0]        out_status;
  logic signed [VAL_W-1:0] out_result_value;

  // Answer forced by a typed directed row, travels with the token beat
  bit                      row_typed = 1'b0;
  status_t                 row_sts = STS_ACCEPTED;
  logic [VAL_W-1:0]        row_val = '0;

  // Shadow stack of the predictor
  logic [VAL_W-1:0]        held_vals [STK_DEPTH];
  int unsigned             held_count = 0;
  int unsigned             held_peak = 0;

  token_result_t           awaited [$];
  int unsigned             tokens_offered = 0;
  int unsigned             tokens_taken = 0;
  int unsigned             results_taken = 0;
  int unsigned             err_count = 0;
  bit                      quiet = 1'b0;
  bit                      long_hold_req = 1'b0;

  int unsigned             n_push = 0, n_oper = 0, n_end = 0, n_spare = 0;
  int unsigned             n_ready = 0, n_invalid = 0, n_divzero = 0, n_overflow = 0;

  rpn_stack_evaluator_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_operand_value (in_operand_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_result_value (out_result_value)
  );

  always #5 clk = ~clk;

  // Evaluate one token against the shadow stack
  function automatic token_result_t eval_token(logic [REQ_W-1:0] kind, logic [VAL_W-1:0] opnd);
    token_result_t    r;
    logic [VAL_W-1:0] rhs, lhs, nmag, dmag, quo, res;
    r.sts = STS_ACCEPTED;
    r.val = '0;
    case (kind)
      REQ_PUSH: begin
        if (held_count >= STK_DEPTH) begin
          held_count = 0;
          r.sts = STS_OVERFLOW;
        end else begin
          held_vals[held_count] = opnd;
          held_count++;
        end
      end
      REQ_END: begin
        if (held_count == 1) begin
          r.sts = STS_READY;
          r.val = held_vals[0];
        end else begin
          r.sts = STS_INVALID;
        end
        held_count = 0;
      end
      REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV: begin
        if (held_count < 2) begin
          held_count = 0;
          r.sts = STS_INVALID;
        end else begin
          // top of stack is the right-hand operand
          rhs = held_vals[held_count-1];
          lhs = held_vals[held_count-2];
          held_count -= 2;
          res = '0;
          if (kind == REQ_ADD) res = lhs + rhs;
          else if (kind == REQ_SUB) res = lhs - rhs;
          else if (kind == REQ_MUL) res = lhs * rhs;
          else if (rhs != '0) begin
            // truncate toward zero via magnitudes
            nmag = lhs[VAL_W-1] ? -lhs : lhs;
            dmag = rhs[VAL_W-1] ? -rhs : rhs;
            quo  = nmag / dmag;
            res  = (lhs[VAL_W-1] != rhs[VAL_W-1]) ? -quo : quo;
          end
          if (kind == REQ_DIV && rhs == '0) begin
            held_count = 0;
            r.sts = STS_DIVZERO;
          end else begin
            held_vals[held_count] = res;
            held_count++;
          end
        end
      end
      default: begin
        held_count = 0;
        r.sts = STS_INVALID;
      end
    endcase
    if (held_count > held_peak) held_peak = held_count;
    return r;
  endfunction

  // Check result beats, record expectations for token beats
  always @(posedge clk) begin : scoreboard
    token_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_taken++;
        if (awaited.size() == 0) begin
          err_count++;
          $display("%0t: result beat with nothing expected: status %0d value %h",
                   $time, out_status, out_result_value);
        end else begin
          want = awaited.pop_front();
          if (out_status !== want.sts) begin
            err_count++;
            $display("%0t: status expected %0d actual %0d", $time, want.sts, out_status);
          end
          if (out_result_value !== want.val) begin
            err_count++;
            $display("%0t: result_value expected %h actual %h",
                     $time, want.val, out_result_value);
          end
        end
      end
      if (in_valid && !in_stall) begin
        tokens_taken++;
        want = eval_token(in_req_type, in_operand_value);
        if (row_typed) begin
          want.sts = row_sts;
          want.val = row_val;
        end
        awaited.push_back(want);
        case (in_req_type)
          REQ_PUSH: n_push++;
          REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV: n_oper++;
          REQ_END: n_end++;
          default: n_spare++;
        endcase
        case (want.sts)
          STS_READY:    n_ready++;
          STS_INVALID:  n_invalid++;
          STS_DIVZERO:  n_divzero++;
          STS_OVERFLOW: n_overflow++;
          default: ;
        endcase
      end
    end
  end

  // End the run when no beat moves on either side for too long
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("%0t: no beat for %0d cycles, %0d results outstanding",
             $time, IDLE_LIMIT, awaited.size());
    $display("rpn_stack_evaluator_core: mismatch");
    $finish;
  end

  // Result side: stall a random number of cycles ahead of each result beat
  initial begin : receiver
    int unsigned hold, mark;
    wait (rst_n);
    @(negedge clk);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 15);
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      mark = results_taken;
      do @(negedge clk); while (results_taken == mark);
    end
  end

  // Offer one token beat after a random gap and hold it until taken
  task automatic send_token(logic [REQ_W-1:0] kind, logic [VAL_W-1:0] opnd,
                            bit typed, status_t sts, logic [VAL_W-1:0] val);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_req_type      <= kind;
    in_operand_value <= opnd;
    row_typed        <= typed;
    row_sts          <= sts;
    row_val          <= val;
    tokens_offered++;
    do @(negedge clk); while (tokens_taken < tokens_offered);
  endtask

  // Drop the offer and wait until every result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(negedge clk);
  endtask

  // Mix of full-range, small, extreme and small positive operands
  function automatic logic [VAL_W-1:0] draw_operand();
    int unsigned             pick;
    logic signed [VAL_W-1:0] s;
    pick = $urandom_range(0, 9);
    if (pick < 4) return {$urandom, $urandom};
    if (pick < 8) begin
      s = VAL_W'($urandom_range(0, 128));
      return s - 64;
    end
    if (pick == 9) return VAL_W'($urandom_range(1, 9));
    case ($urandom_range(0, 4))
      0: return VMIN;
      1: return VMAX;
      2: return VZERO;
      3: return VNEG1;
      default: return VONE;
    endcase
  endfunction

  // Well-formed expression with n_ops operators; a short one stops an operator
  // early so the end token sees two values
  task automatic run_expression(int unsigned n_ops, bit short_one);
    int unsigned      held, ops_left, pushes_left;
    logic [REQ_W-1:0] kind;
    held = 0;
    ops_left = short_one ? n_ops - 1 : n_ops;
    pushes_left = n_ops + 1;
    while (pushes_left + ops_left > 0) begin
      if (held >= 2 && ops_left > 0 &&
          (pushes_left == 0 || held >= STK_DEPTH || $urandom_range(0, 1) == 1)) begin
        case ($urandom_range(0, 3))
          0: kind = REQ_ADD;
          1: kind = REQ_SUB;
          2: kind = REQ_MUL;
          default: kind = REQ_DIV;
        endcase
        send_token(kind, {$urandom, $urandom}, 1'b0, STS_ACCEPTED, VZERO);
        held--;
        ops_left--;
      end else begin
        send_token(REQ_PUSH, draw_operand(), 1'b0, STS_ACCEPTED, VZERO);
        held++;
        pushes_left--;
      end
    end
    send_token(REQ_END, {$urandom, $urandom}, 1'b0, STS_ACCEPTED, VZERO);
  endtask

  initial begin : stimulus
    int unsigned seq, pick, n_ops, cnt;
    dir_row_t    row;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table
    for (int i = 0; i < 25; i++) begin
      row = DIR_TABLE[i];
      send_token(row.kind, row.opnd, row.typed, row.sts, row.val);
    end
    wait_drained();

    // Random expressions, stack fills and noise
    seq = 0;
    while (tokens_offered < ITEM_TARGET) begin
      quiet = ($urandom_range(0, 4) == 0);
      if (seq == 3) long_hold_req = 1'b1;
      if (seq % 30 == 29) wait_drained();
      pick  = $urandom_range(0, 19);
      n_ops = ($urandom_range(0, 4) == 0) ? $urandom_range(7, STK_DEPTH - 1)
                                          : $urandom_range(1, 6);
      if (seq == 0 || pick == 0) begin
        // push a full stack's worth, up to two past the top
        cnt = $urandom_range(STK_DEPTH, STK_DEPTH + 2);
        repeat (cnt) send_token(REQ_PUSH, draw_operand(), 1'b0, STS_ACCEPTED, VZERO);
        send_token(REQ_END, VZERO, 1'b0, STS_ACCEPTED, VZERO);
      end else if (pick < 4) begin
        // any code, including the unused ones
        cnt = $urandom_range(1, 8);
        repeat (cnt)
          send_token(REQ_W'($urandom_range(0, (1 << REQ_W) - 1)), draw_operand(),
                     1'b0, STS_ACCEPTED, VZERO);
      end else if (pick < 6) begin
        run_expression(n_ops, 1'b1);
      end else begin
        run_expression(($urandom_range(0, 5) == 0) ? 0 : n_ops, 1'b0);
      end
      seq++;
    end

    // Drain, then watch for stray result beats
    quiet = 1'b1;
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d tokens: %0d push, %0d operator, %0d end, %0d unused code;",
             tokens_taken, n_push, n_oper, n_end, n_spare);
    $display("%0d results: ready %0d, invalid %0d, divide by zero %0d, overflow %0d; deepest %0d",
             results_taken, n_ready, n_invalid, n_divzero, n_overflow, held_peak);
    if (err_count == 0) begin
      $display("rpn_stack_evaluator_core: match");
    end else begin
      $display("rpn_stack_evaluator_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/rpn_pkg.sv
rtl/rpn_stack_evaluator_core.sv
bench/rpn_stack_evaluator_core_tb.sv
